### design/point_in_polygon_test_macros.svh
// Assertion helpers for the checker in pip_checker.sv.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pip_pkg.sv
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 24;
	localparam int VIDX_W       = 6;
	localparam int CFG_W        = 7;

	// Differences of two coordinates and products of two differences.
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	// Wide enough to hold MAX_VERTICES itself.
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > VIDX_W) ? CNT_W : VIDX_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DW-1:0]         diff_t;
	typedef logic signed [PW-1:0]         prod_t;

	typedef enum logic [0:0] {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [VIDX_W-1:0]  vidx;
		coord_t             px;
		coord_t             pz;
		logic               odd;
		logic               onb;
	} item_t;

	function automatic diff_t coord_sub(coord_t a, coord_t b);
		return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
	endfunction

endpackage

### design/pip_cfg.sv
module pip_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pip_pkg::PADDR_W-1:0]  paddr,
	input  logic [pip_pkg::PDATA_W-1:0]  pwdata,
	output logic [pip_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [pip_pkg::CNT_W-1:0]    active_count
);

	localparam int CW = (pip_pkg::CNT_W > pip_pkg::CFG_W) ? pip_pkg::CNT_W : pip_pkg::CFG_W;

	logic [pip_pkg::CFG_W-1:0] vertex_count_q;
	logic                      reg_sel;
	logic [CW-1:0]             cnt_ext;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[pip_pkg::PADDR_W-1] == pip_pkg::REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			vertex_count_q <= pwdata[pip_pkg::CFG_W-1:0];
		end
	end

	assign prdata = reg_sel ? pip_pkg::PDATA_W'(vertex_count_q) : '0;

	// A count above the number of cells is treated as a full polygon.
	always_comb begin
		cnt_ext = CW'(vertex_count_q);
		if (cnt_ext > CW'(pip_pkg::MAX_VERTICES)) begin
			active_count = pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);
		end else begin
			active_count = pip_pkg::CNT_W'(cnt_ext);
		end
	end

endmodule

### design/pip_cell.sv
module pip_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [pip_pkg::CNT_W-1:0]  cell_idx,
	input  logic [pip_pkg::CNT_W-1:0]  active_count,
	input  logic                       in_valid,
	input  pip_pkg::item_t             in_item,
	output logic                       out_valid,
	output pip_pkg::item_t             out_item
);

	// Own vertex, the following vertex and vertex 0 (for the closing edge).
	pip_pkg::coord_t ax_q, az_q, bx_q, bz_q, fx_q, fz_q;

	logic [pip_pkg::CMP_W-1:0] idx_ext, self_idx, next_idx;
	logic                      is_last, is_active, is_load;
	pip_pkg::coord_t           nx, nz, hx, hz, lx, lz;
	logic                      crosses;

	logic            valid_s1, valid_s2, valid_s3;
	pip_pkg::item_t  item_s1, item_s2, item_s3;
	logic            cross_s1, cross_s2;
	pip_pkg::diff_t  opa_s1, opb_s1, opc_s1, opd_s1;
	pip_pkg::prod_t  p_s2, q_s2;
	logic [pip_pkg::PW:0] side;
	pip_pkg::item_t  item_nxt;

	assign idx_ext   = pip_pkg::CMP_W'(in_item.vidx);
	assign self_idx  = pip_pkg::CMP_W'(cell_idx);
	assign next_idx  = self_idx + pip_pkg::CMP_W'(1);
	assign is_last   = (next_idx == pip_pkg::CMP_W'(active_count));
	assign is_active = (cell_idx < active_count);
	assign is_load   = (in_item.mode == pip_pkg::MODE_LOAD);

	// Loads travel along the chain, so every request sees the polygon as it
	// stood when that request was accepted.
	always_ff @(posedge clk) begin
		if (en && in_valid && is_load) begin
			if (idx_ext == self_idx) begin
				ax_q <= in_item.px;
				az_q <= in_item.pz;
			end
			if (idx_ext == next_idx) begin
				bx_q <= in_item.px;
				bz_q <= in_item.pz;
			end
			if (idx_ext == '0) begin
				fx_q <= in_item.px;
				fz_q <= in_item.pz;
			end
		end
	end

	always_comb begin
		nx = is_last ? fx_q : bx_q;
		nz = is_last ? fz_q : bz_q;
		if (az_q < nz) begin
			hx = nx;   hz = nz;
			lx = ax_q; lz = az_q;
		end else begin
			hx = ax_q; hz = az_q;
			lx = nx;   lz = nz;
		end
		// The edge spans the point's z, and a horizontal edge at that z is skipped.
		crosses = is_active && !is_load && !(hz < in_item.pz) && !(lz > in_item.pz) &&
			!((hz == in_item.pz) && (lz == in_item.pz));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Sign of (px - xh) * dz - (xl - xh) * (zh - pz) gives the side of the crossing.
	assign side = {p_s2[pip_pkg::PW-1], p_s2} - {q_s2[pip_pkg::PW-1], q_s2};

	always_comb begin
		item_nxt = item_s2;
		if (cross_s2) begin
			if (side == '0) begin
				item_nxt.onb = 1'b1;
			end else if (side[pip_pkg::PW]) begin
				item_nxt.odd = ~item_s2.odd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;
			cross_s1 <= crosses;
			opa_s1   <= pip_pkg::coord_sub(in_item.px, hx);
			opb_s1   <= pip_pkg::coord_sub(hz, lz);
			opc_s1   <= pip_pkg::coord_sub(lx, hx);
			opd_s1   <= pip_pkg::coord_sub(hz, in_item.pz);

			item_s2  <= item_s1;
			cross_s2 <= cross_s1;
			p_s2     <= opa_s1 * opb_s1;
			q_s2     <= opc_s1 * opd_s1;

			item_s3  <= item_nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

### design/point_in_polygon_test.sv
// Path: a query accepted at the input passes every vertex cell and then the output register to out_valid.
// Throughput: one request per cycle; each of the MAX_VERTICES vertex cells has three register
// stages (edge select, multiply, side compare) and the chain only halts while a result at its
// end meets a full output register. Loads give no result.
// Reset: arst_n clears the vertex count, all valid bits and the output valid flag at once;
// vertex registers are not reset and need no clearing pass.
module point_in_polygon_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [pip_pkg::VIDX_W-1:0]      vertex_index,
	input  logic signed [pip_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [pip_pkg::COORD_BITS-1:0] point_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            inside_res,
	output logic                            on_boundary,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pip_pkg::PADDR_W-1:0]     paddr,
	input  logic [pip_pkg::PDATA_W-1:0]     pwdata,
	output logic [pip_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [pip_pkg::CNT_W-1:0] active_count;
	logic                      chain_valid [0:pip_pkg::MAX_VERTICES];
	pip_pkg::item_t            chain_item  [0:pip_pkg::MAX_VERTICES];
	logic                      en, last_query;
	logic                      out_valid_q, inside_q, onb_q;
	pip_pkg::item_t            last_item;

	pip_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.active_count (active_count)
	);

	assign last_item  = chain_item[pip_pkg::MAX_VERTICES];
	assign last_query = chain_valid[pip_pkg::MAX_VERTICES] &&
		(last_item.mode == pip_pkg::MODE_QUERY);

	// The chain halts only when a result must leave and the output register cannot take it.
	assign en       = !(out_valid_q && !out_ready && last_query);
	assign in_ready = en;

	assign chain_valid[0] = in_valid && in_ready;
	always_comb begin
		chain_item[0].mode = pip_pkg::mode_t'(mode);
		chain_item[0].vidx = vertex_index;
		chain_item[0].px   = point_x;
		chain_item[0].pz   = point_z;
		chain_item[0].odd  = 1'b0;
		chain_item[0].onb  = 1'b0;
	end

	for (genvar g = 0; g < pip_pkg::MAX_VERTICES; g++) begin : g_cell
		pip_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (en),
			.cell_idx     (pip_pkg::CNT_W'(g)),
			.active_count (active_count),
			.in_valid     (chain_valid[g]),
			.in_item      (chain_item[g]),
			.out_valid    (chain_valid[g+1]),
			.out_item     (chain_item[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= last_query;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			inside_q <= last_item.odd || last_item.onb;
			onb_q    <= last_item.onb;
		end
	end

	assign out_valid   = out_valid_q;
	assign inside_res  = inside_q;
	assign on_boundary = onb_q;

endmodule

### design/pip_checker.sv
`include "point_in_polygon_test_macros.svh"

module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic inside_res,
	input logic on_boundary
);

	// A point on the boundary always counts as inside.
	`PIP_ASSERT_SAME(a_onb_inside, out_valid && on_boundary, inside_res, "boundary result not inside")

	// Requests are refused only while a result is held back at the output.
	`PIP_ASSERT_SAME(a_ready_free, !in_ready, out_valid && !out_ready, "input stalled without cause")

	// A held result keeps its value until taken.
	`PIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(inside_res) && $stable(on_boundary), "held result changed")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
